// File: design/rmth_pkg.sv
`default_nettype none
package rmth_pkg;
    localparam int VALUE_W = 25;
    localparam int COUNT_W = 11;
    localparam logic [VALUE_W-1:0] SUM_MOD = 25'd20090711;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b00000000001,
        ST_PUSH_RD = 11'b00000000010,
        ST_PUSH_CMP= 11'b00000000100,
        ST_TOP_RD  = 11'b00000001000,
        ST_TOP_CMP = 11'b00000010000,
        ST_SD_RD   = 11'b00000100000,
        ST_SD_RD2  = 11'b00001000000,
        ST_SD_CMP  = 11'b00010000000,
        ST_SUM     = 11'b00100000000,
        ST_SUM2    = 11'b01000000000,
        ST_OUT     = 11'b10000000000
    } state_t;
endpackage
`default_nettype wire

// File: design/rmth_ram.sv
`default_nettype none
module rmth_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/running_median_two_heaps.sv
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_ready  | value, restart
// output  | out       | out_valid/out_ready| median, median_sum, item_count, rejected
//
// flow: a refused item goes straight from the accepting cycle to the result;
//   an accepted item is sifted up, then, if the tops are out of order, the two tops
//   are swapped and each heap is sifted down; each sift works one heap level at a
//   time, set by the single read port of each heap memory
// reset: clears sizes, running sum and the sequencer; heap memories are not cleared
// stalls: a finished result sits in the output register; in_ready is low
//   while an item is in work or a result waits
`default_nettype none
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               restart,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [VALUE_W-1:0]      median,
    output logic [VALUE_W-1:0]      median_sum,
    output logic [COUNT_W-1:0]      item_count,
    output logic                    rejected
);
    localparam int HALF = (CAPACITY + 1) / 2;
    localparam int AW = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int SW = $clog2(HALF + 1);

    state_t state_reg, state_next;
    logic [SW-1:0] lsize_reg, lsize_next, usize_reg, usize_next;
    logic [VALUE_W-1:0] sum_reg, sum_next;
    logic [VALUE_W-1:0] ltop_reg, ltop_next, utop_reg, utop_next;
    // work registers
    logic               heap_sel_reg, heap_sel_next;   // 1: upper (min) heap
    logic [SW-1:0]      idx_reg, idx_next, best_reg, best_next;
    logic [VALUE_W-1:0] cur_reg, cur_next;              // value being placed
    logic [VALUE_W-1:0] cand_reg, cand_next;            // best child so far
    logic               has_cand_reg, has_cand_next;
    logic [VALUE_W-1:0] other_reg, other_next;          // lower top for swap
    logic               second_reg, second_next;        // second sift-down pending
    logic               rej_reg, rej_next;
    logic [VALUE_W-1:0] med_out_reg, med_out_next;

    logic               we_l, we_u;
    logic [AW-1:0]      waddr, raddr;
    logic [VALUE_W-1:0] wdata, rd_l, rd_u, rd;
    logic [SW:0]        sum_idx;
    logic [SW-1:0]      parent, lchild, rchild, hsize;
    logic               above;

    rmth_ram #(.WIDTH(VALUE_W), .DEPTH(HALF)) u_lower (
        .clk(clk), .we(we_l), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_l)
    );
    rmth_ram #(.WIDTH(VALUE_W), .DEPTH(HALF)) u_upper (
        .clk(clk), .we(we_u), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_u)
    );

    assign rd      = heap_sel_reg ? rd_u : rd_l;
    assign hsize   = heap_sel_reg ? usize_reg : lsize_reg;
    assign parent  = (idx_reg - SW'(1)) >> 1;
    assign lchild  = SW'({idx_reg, 1'b1});
    assign rchild  = lchild + SW'(1);
    assign sum_idx = {1'b0, lsize_reg} + {1'b0, usize_reg};

    // shared compare: does a sit above b in the selected heap
    function automatic logic ranks(input logic a_min, input logic [VALUE_W-1:0] a,
                                   input logic [VALUE_W-1:0] b);
        ranks = a_min ? (a < b) : (a > b);
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        lsize_next    = lsize_reg;
        usize_next    = usize_reg;
        sum_next      = sum_reg;
        ltop_next     = ltop_reg;
        utop_next     = utop_reg;
        heap_sel_next = heap_sel_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        cur_next      = cur_reg;
        cand_next     = cand_reg;
        has_cand_next = has_cand_reg;
        other_next    = other_reg;
        second_next   = second_reg;
        rej_next      = rej_reg;
        med_out_next  = med_out_reg;
        we_l = 1'b0;
        we_u = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = cur_reg;
        raddr = parent[AW-1:0];
        above = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    logic [SW-1:0] ls, us;
                    ls = restart ? '0 : lsize_reg;
                    us = restart ? '0 : usize_reg;
                    if (restart)
                    begin
                        sum_next = '0;
                    end
                    lsize_next = ls;
                    usize_next = us;
                    cur_next   = value;
                    if (({1'b0, ls} + {1'b0, us}) >= (SW+1)'(CAPACITY))
                    begin
                        rej_next     = 1'b1;
                        med_out_next = ltop_reg;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        rej_next      = 1'b0;
                        heap_sel_next = (ls != us);
                        idx_next      = (ls != us) ? us : ls;
                        if (ls == us)
                        begin
                            lsize_next = ls + SW'(1);
                        end
                        else
                        begin
                            usize_next = us + SW'(1);
                        end
                        state_next = ST_PUSH_RD;
                    end
                end
            end
            ST_PUSH_RD:
            begin
                // read parent, or place at root
                if (idx_reg == '0)
                begin
                    we_l = !heap_sel_reg;
                    we_u = heap_sel_reg;
                    if (heap_sel_reg) utop_next = cur_reg; else ltop_next = cur_reg;
                    state_next = ST_TOP_RD;
                end
                else
                begin
                    raddr = parent[AW-1:0];
                    state_next = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP:
            begin
                above = ranks(heap_sel_reg, cur_reg, rd);
                if (above)
                begin
                    // move parent down, continue upward
                    wdata = rd;
                    we_l = !heap_sel_reg;
                    we_u = heap_sel_reg;
                    idx_next = parent;
                    state_next = ST_PUSH_RD;
                end
                else
                begin
                    we_l = !heap_sel_reg;
                    we_u = heap_sel_reg;
                    state_next = ST_TOP_RD;
                end
            end
            ST_TOP_RD:
            begin
                if (usize_reg != '0 && utop_reg < ltop_reg)
                begin
                    // lower heap gets upper top first, then upper gets old lower top
                    other_next    = ltop_reg;
                    cur_next      = utop_reg;
                    ltop_next     = utop_reg;
                    utop_next     = ltop_reg;
                    heap_sel_next = 1'b0;
                    idx_next      = '0;
                    second_next   = 1'b1;
                    state_next    = ST_SD_RD;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_TOP_CMP:
            begin
                // start sift-down on upper heap
                cur_next      = other_reg;
                heap_sel_next = 1'b1;
                idx_next      = '0;
                second_next   = 1'b0;
                state_next    = ST_SD_RD;
            end
            ST_SD_RD:
            begin
                has_cand_next = 1'b0;
                if ({1'b0, lchild} < {1'b0, hsize} && idx_reg < SW'(HALF / 2 + 1))
                begin
                    raddr = lchild[AW-1:0];
                    state_next = ST_SD_RD2;
                end
                else
                begin
                    we_l = !heap_sel_reg;
                    we_u = heap_sel_reg;
                    state_next = second_reg ? ST_TOP_CMP : ST_SUM;
                end
            end
            ST_SD_RD2:
            begin
                // left child data arrives; issue right child read
                cand_next     = rd;
                best_next     = lchild;
                has_cand_next = 1'b1;
                raddr         = rchild[AW-1:0];
                state_next    = ST_SD_CMP;
            end
            ST_SD_CMP:
            begin
                logic [VALUE_W-1:0] bv;
                logic [SW-1:0]      bi;
                bv = cand_reg;
                bi = best_reg;
                if (rchild < hsize && ranks(heap_sel_reg, rd, cand_reg))
                begin
                    bv = rd;
                    bi = rchild;
                end
                if (ranks(heap_sel_reg, bv, cur_reg))
                begin
                    wdata = bv;
                    we_l = !heap_sel_reg;
                    we_u = heap_sel_reg;
                    // a child moving into the root becomes the new top
                    if (idx_reg == '0)
                    begin
                        if (heap_sel_reg) utop_next = bv; else ltop_next = bv;
                    end
                    idx_next = bi;
                    state_next = ST_SD_RD;
                end
                else
                begin
                    we_l = !heap_sel_reg;
                    we_u = heap_sel_reg;
                    state_next = second_reg ? ST_TOP_CMP : ST_SUM;
                end
            end
            ST_SUM:
            begin
                logic [VALUE_W:0] s;
                s = {1'b0, sum_reg} + {1'b0, ltop_reg};
                sum_next = s[VALUE_W-1:0];
                if (s >= {1'b0, SUM_MOD})
                begin
                    sum_next = VALUE_W'(s - {1'b0, SUM_MOD});
                end
                med_out_next = ltop_reg;
                state_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                // second fold: the median alone can exceed the modulus
                if (sum_reg >= SUM_MOD)
                begin
                    sum_next = sum_reg - SUM_MOD;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lsize_reg <= '0;
            usize_reg <= '0;
            sum_reg   <= '0;
            ltop_reg  <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lsize_reg <= lsize_next;
            usize_reg <= usize_next;
            sum_reg   <= sum_next;
            ltop_reg  <= ltop_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        utop_reg     <= utop_next;
        heap_sel_reg <= heap_sel_next;
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        cur_reg      <= cur_next;
        cand_reg     <= cand_next;
        has_cand_reg <= has_cand_next;
        other_reg    <= other_next;
        rej_reg      <= rej_next;
        med_out_reg  <= med_out_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign median     = med_out_reg;
    assign median_sum = sum_reg;
    assign item_count = COUNT_W'(sum_idx);
    assign rejected   = rej_reg;
endmodule
`default_nettype wire

// File: design/rmth_checker.sv
`default_nettype none
module rmth_checker
    import rmth_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [VALUE_W-1:0] median_sum,
    input wire logic [COUNT_W-1:0] item_count,
    input wire logic               rejected
);
    // one item at a time: no input transfer while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input open while result pending");

    // an accepted item keeps the input closed on the next cycle
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("input open right after transfer");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> median_sum < SUM_MOD) else $error("sum out of range");

    a_rej_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> item_count != '0) else $error("reject on empty store");

    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(median_sum))
        else $error("result dropped");
endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .median_sum(median_sum),
    .item_count(item_count), .rejected(rejected)
);
`default_nettype wire

// File: tb/running_median_two_heaps_tb.sv
`default_nettype none
module running_median_two_heaps_tb;
    import rmth_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 1024;
    localparam int HALF = (CAP + 1) / 2;

    // one expected result, as the block should report it
    typedef struct {
        logic [VALUE_W-1:0] median;
        logic [VALUE_W-1:0] median_sum;
        logic [COUNT_W-1:0] item_count;
        logic               rejected;
    } median_result_t;

    // software copy of the two-heap median keeper plus the queue of pending results
    class median_scoreboard;
        logic [VALUE_W-1:0] lo_heap[HALF];
        logic [VALUE_W-1:0] hi_heap[HALF];
        int unsigned lo_n;
        int unsigned hi_n;
        logic [VALUE_W-1:0] sum_q;
        median_result_t pending[$];
        int errors;

        function new();
            lo_n = 0;
            hi_n = 0;
            sum_q = '0;
            errors = 0;
        endfunction

        function bit above(logic [VALUE_W-1:0] x, logic [VALUE_W-1:0] y, bit is_max);
            return is_max ? (x > y) : (x < y);
        endfunction

        // sift-up insert; lower heap is a max-heap, upper a min-heap
        function void push(bit is_max, logic [VALUE_W-1:0] v);
            int unsigned i;
            int unsigned p;
            logic [VALUE_W-1:0] t;
            if (is_max)
            begin
                i = lo_n;
                lo_heap[i] = v;
                lo_n++;
                while (i > 0)
                begin
                    p = (i - 1) / 2;
                    if (!above(lo_heap[i], lo_heap[p], 1))
                        break;
                    t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
                    i = p;
                end
            end
            else
            begin
                i = hi_n;
                hi_heap[i] = v;
                hi_n++;
                while (i > 0)
                begin
                    p = (i - 1) / 2;
                    if (!above(hi_heap[i], hi_heap[p], 0))
                        break;
                    t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
                    i = p;
                end
            end
        endfunction

        // put v at the top and sift it down
        function void replace_top(bit is_max, logic [VALUE_W-1:0] v);
            int unsigned i;
            int unsigned l;
            int unsigned best;
            int unsigned n;
            logic [VALUE_W-1:0] t;
            i = 0;
            n = is_max ? lo_n : hi_n;
            if (is_max) lo_heap[0] = v; else hi_heap[0] = v;
            forever
            begin
                l = 2 * i + 1;
                best = i;
                if (is_max)
                begin
                    if (l < n && above(lo_heap[l], lo_heap[best], 1)) best = l;
                    if (l + 1 < n && above(lo_heap[l+1], lo_heap[best], 1)) best = l + 1;
                    if (best == i) break;
                    t = lo_heap[i]; lo_heap[i] = lo_heap[best]; lo_heap[best] = t;
                end
                else
                begin
                    if (l < n && above(hi_heap[l], hi_heap[best], 0)) best = l;
                    if (l + 1 < n && above(hi_heap[l+1], hi_heap[best], 0)) best = l + 1;
                    if (best == i) break;
                    t = hi_heap[i]; hi_heap[i] = hi_heap[best]; hi_heap[best] = t;
                end
                i = best;
            end
        endfunction

        function void note_input(logic [VALUE_W-1:0] v, logic rs);
            median_result_t r;
            logic [VALUE_W-1:0] a;
            logic [VALUE_W-1:0] b;
            logic [VALUE_W:0] s;
            r.rejected = 1'b0;
            if (rs)
            begin
                lo_n = 0;
                hi_n = 0;
                sum_q = '0;
            end
            if (lo_n + hi_n >= CAP)
                r.rejected = 1'b1;
            else
            begin
                push(lo_n == hi_n, v);
                if (lo_n > 0 && hi_n > 0 && hi_heap[0] < lo_heap[0])
                begin
                    a = lo_heap[0];
                    b = hi_heap[0];
                    replace_top(1, b);
                    replace_top(0, a);
                end
                s = {1'b0, sum_q} + {1'b0, lo_heap[0]};
                sum_q = VALUE_W'(s % SUM_MOD);
            end
            r.median = (lo_n > 0) ? lo_heap[0] : '0;
            r.median_sum = sum_q;
            r.item_count = COUNT_W'(lo_n + hi_n);
            pending.push_back(r);
        endfunction

        function void check_result(median_result_t got);
            median_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result median=%0d sum=%0d count=%0d rej=%0b",
                         $time, got.median, got.median_sum, got.item_count, got.rejected);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.median !== e.median)
            begin
                $display("%0t: median expected %0d actual %0d", $time, e.median, got.median);
                errors++;
            end
            if (got.median_sum !== e.median_sum)
            begin
                $display("%0t: median_sum expected %0d actual %0d",
                         $time, e.median_sum, got.median_sum);
                errors++;
            end
            if (got.item_count !== e.item_count)
            begin
                $display("%0t: item_count expected %0d actual %0d",
                         $time, e.item_count, got.item_count);
                errors++;
            end
            if (got.rejected !== e.rejected)
            begin
                $display("%0t: rejected expected %0b actual %0b",
                         $time, e.rejected, got.rejected);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] value = '0;
    logic               restart = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [VALUE_W-1:0] median;
    logic [VALUE_W-1:0] median_sum;
    logic [COUNT_W-1:0] item_count;
    logic               rejected;

    median_scoreboard sb = new();
    bit calm = 1'b0;   // set in the last part of the run: no idling on either side
    bit burst_mode = 1'b0; // long stretches with no idling

    running_median_two_heaps #(.CAPACITY(CAP)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .value(value), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready),
        .median(median), .median_sum(median_sum),
        .item_count(item_count), .rejected(rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop; the whole run sends ~1250 items
    initial
    begin
        #50ms;
        $display("running_median_two_heaps_tb: errors");
        $finish;
    end

    // output side: sample at the rising edge, change ready at the falling edge
    always @(posedge clk)
    begin
        median_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.median = median;
            got.median_sum = median_sum;
            got.item_count = item_count;
            got.rejected = rejected;
            sb.check_result(got);
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && !burst_mode && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // one transfer on the input channel; valid held until accepted
    task automatic send_sample(logic [VALUE_W-1:0] v, logic rs);
        // valid was dropped at the last falling edge; raise it at a later one
        @(negedge clk);
        if (!calm && !burst_mode && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        in_valid <= 1'b1;
        value <= v;
        restart <= rs;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(v, rs);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VALUE_W'($urandom_range(0, 15));
            3: return VALUE_W'($urandom_range(20090700, 20090720));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int k;
        int run;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, equal values, descending/ascending runs, restart
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(25'd20090711, 1'b0);
        send_sample(25'd5, 1'b0);
        send_sample(25'd5, 1'b0);
        for (k = 0; k < 6; k++)
            send_sample(VALUE_W'(100 - k * 10), 1'b0);
        for (k = 0; k < 6; k++)
            send_sample(VALUE_W'(k * 7), 1'b0);
        send_sample(25'h0AAAAAA, 1'b1);
        send_sample(25'h1555555, 1'b0);
        send_sample('1, 1'b1);
        send_sample('1, 1'b0);

        // fill the store to capacity with no idling, then refusals, then restart on full
        burst_mode = 1'b1;
        send_sample(rand_value(), 1'b1);
        for (k = 1; k < CAP; k++)
            send_sample(rand_value(), 1'b0);
        burst_mode = 1'b0;
        send_sample(25'd1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample(25'd77, 1'b1);

        // random runs of mostly small sets with occasional restarts
        for (k = 0; k < 200; k++)
        begin
            if (k > 150)
                calm = 1'b1;
            run = $urandom_range(0, 39);
            send_sample(rand_value(), run == 0);
        end

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (sb.errors == 0)
            $display("running_median_two_heaps_tb: clean");
        else
            $display("running_median_two_heaps_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
design/rmth_pkg.sv
design/rmth_ram.sv
design/running_median_two_heaps.sv
design/rmth_checker.sv
tb/running_median_two_heaps_tb.sv
